// ===== src/process_slot_table_round_robin_core_macros.svh =====
// Assertion macros shared by the slot table RTL.
`ifndef PROCESS_SLOT_TABLE_ROUND_ROBIN_CORE_MACROS_SVH
`define PROCESS_SLOT_TABLE_ROUND_ROBIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under clk, off during reset.
`define PSTRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot table check failed");
// Next-cycle implication under clk, off during reset.
`define PSTRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot table check failed");
`else
`define PSTRR_ASSERT_NOW(label, ante, cons)
`define PSTRR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/pstrr_pkg.sv =====
// Types and constants of the task slot table.
package pstrr_pkg;

  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned TASK_ID_W = 32;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_SET_READY = 2'd2,
    OP_SCHEDULE  = 2'd3
  } op_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FAIL = 1'b1
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    granted_slot;
    logic [TASK_ID_W-1:0] task_id;
  } out_t;

endpackage

// ===== src/pstrr_pick.sv =====
// First-free and rotating-ready encoders over the slot table.
module pstrr_pick #(
  parameter int unsigned SLOT_COUNT = 32,
  parameter int unsigned PW         = 5
) (
  input  logic [SLOT_COUNT-1:0] busy,
  input  logic [SLOT_COUNT-1:0] ready,
  input  logic [PW-1:0]         ptr,
  output logic                  alloc_found,
  output logic [PW-1:0]         alloc_idx,
  output logic                  sched_found,
  output logic [PW-1:0]         sched_idx
);

  logic          hi_found;
  logic [PW-1:0] hi_idx;
  logic          lo_found;
  logic [PW-1:0] lo_idx;

  // lowest unused slot, slot 0 included
  always_comb begin
    alloc_found = 1'b0;
    alloc_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        alloc_found = 1'b1;
        alloc_idx   = PW'(i);
      end
    end
  end

  // lowest ready slot above the pointer, else lowest ready slot from 1 up
  always_comb begin
    hi_found = 1'b0;
    hi_idx   = '0;
    lo_found = 1'b0;
    lo_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
      if (ready[i]) begin
        lo_found = 1'b1;
        lo_idx   = PW'(i);
        if (PW'(i) > ptr) begin
          hi_found = 1'b1;
          hi_idx   = PW'(i);
        end
      end
    end
    sched_found = hi_found | lo_found;
    sched_idx   = hi_found ? hi_idx : lo_idx;
  end

endmodule

// ===== src/process_slot_table_round_robin_core.sv =====
// Task slot table: first-free allocation and round-robin scheduling.
//
//   port group  dir  carries
//   in_*        in   request: op, slot
//   out_*       out  result: status, granted_slot, task_id
//
// A request waits in the input register and is resolved into the result
// register; while the result is not stalled, one request a cycle goes through.
// The table state updates on the edge that loads the result, so each request
// sees everything before it. A stalled result holds the input register, and
// in_stall rises only when both registers are full. Synchronous reset empties
// the table, zeroes the id counter and the rotation pointer.
module process_slot_table_round_robin_core #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pstrr_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output pstrr_pkg::out_t out_data
);

`include "process_slot_table_round_robin_core_macros.svh"

  localparam int unsigned PW = $clog2(SLOT_COUNT);
  localparam int unsigned IW = (PW > pstrr_pkg::SLOT_W) ? PW : pstrr_pkg::SLOT_W;

  logic                              req_valid_r, req_valid_nxt;
  pstrr_pkg::in_t                    req_r;
  logic [SLOT_COUNT-1:0]             busy_r, busy_nxt;
  logic [SLOT_COUNT-1:0]             ready_r, ready_nxt;
  logic [pstrr_pkg::TASK_ID_W-1:0]   id_r, id_nxt;
  logic [PW-1:0]                     ptr_r, ptr_nxt;
  logic                              out_valid_r, out_valid_nxt;
  pstrr_pkg::out_t                   out_r, out_nxt;

  logic                              in_take;
  logic                              advance;
  logic                              slot_ok;
  logic [IW-1:0]                     slot_wide;
  logic [PW-1:0]                     slot_idx;
  logic [IW-1:0]                     grant_wide;
  logic [PW-1:0]                     grant_idx;

  logic                              alloc_found;
  logic [PW-1:0]                     alloc_idx;
  logic                              sched_found;
  logic [PW-1:0]                     sched_idx;

  pstrr_pick #(
    .SLOT_COUNT (SLOT_COUNT),
    .PW         (PW)
  ) u_pick (
    .busy        (busy_r),
    .ready       (ready_r),
    .ptr         (ptr_r),
    .alloc_found (alloc_found),
    .alloc_idx   (alloc_idx),
    .sched_found (sched_found),
    .sched_idx   (sched_idx)
  );

  // handshake: resolve when the result register is free or being emptied
  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    priority if (in_take) begin
      req_valid_nxt = 1'b1;
    end else if (advance) begin
      req_valid_nxt = 1'b0;
    end else begin
      req_valid_nxt = req_valid_r;
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign slot_wide = IW'(req_r.slot);
  assign slot_idx  = slot_wide[PW-1:0];
  assign slot_ok   = {{(32 - pstrr_pkg::SLOT_W){1'b0}}, req_r.slot} < 32'(SLOT_COUNT);

  assign grant_idx  = (req_r.op == pstrr_pkg::OP_ALLOC) ? alloc_idx : sched_idx;
  assign grant_wide = IW'(grant_idx);

  // resolve the request held in the input register
  always_comb begin
    busy_nxt             = busy_r;
    ready_nxt            = ready_r;
    id_nxt               = id_r;
    ptr_nxt              = ptr_r;
    out_nxt              = out_r;
    if (advance) begin
      out_nxt.status       = pstrr_pkg::STATUS_OK;
      out_nxt.granted_slot = '0;
      out_nxt.task_id      = '0;
      unique case (req_r.op)
        pstrr_pkg::OP_ALLOC: begin
          if (alloc_found) begin
            busy_nxt[alloc_idx]  = 1'b1;
            ready_nxt[alloc_idx] = 1'b0;
            id_nxt               = id_r + 32'd1;
            out_nxt.granted_slot = grant_wide[pstrr_pkg::SLOT_W-1:0];
            out_nxt.task_id      = id_r;
          end else begin
            out_nxt.status = pstrr_pkg::STATUS_FAIL;
          end
        end
        pstrr_pkg::OP_FREE: begin
          if (slot_ok && busy_r[slot_idx]) begin
            busy_nxt[slot_idx]  = 1'b0;
            ready_nxt[slot_idx] = 1'b0;
          end else begin
            out_nxt.status = pstrr_pkg::STATUS_FAIL;
          end
        end
        pstrr_pkg::OP_SET_READY: begin
          // an unused slot becomes ready as well
          if (slot_ok) begin
            busy_nxt[slot_idx]  = 1'b1;
            ready_nxt[slot_idx] = 1'b1;
          end
        end
        pstrr_pkg::OP_SCHEDULE: begin
          // no ready slot: grant the idle task and keep the pointer
          if (sched_found) begin
            ptr_nxt              = sched_idx;
            out_nxt.granted_slot = grant_wide[pstrr_pkg::SLOT_W-1:0];
          end
        end
        default: begin
          out_nxt.status = pstrr_pkg::STATUS_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= '0;
      ready_r     <= '0;
      id_r        <= '0;
      ptr_r       <= '0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      ready_r     <= ready_nxt;
      id_r        <= id_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
    out_r <= out_nxt;
  end

  `PSTRR_ASSERT_NOW(a_ready_needs_busy, 1'b1, (ready_r & ~busy_r) == '0)
  `PSTRR_ASSERT_NEXT(a_alloc_bumps_id, advance && (req_r.op == pstrr_pkg::OP_ALLOC) && alloc_found, id_r == $past(id_r) + 32'd1)
  `PSTRR_ASSERT_NOW(a_grant_is_ready, advance && (req_r.op == pstrr_pkg::OP_SCHEDULE) && sched_found, ready_r[sched_idx] && (sched_idx != '0))

endmodule
